[rtl/packet_admission_checker_core_macros.svh]
// assertion macros for the rtl, included by pac_ctrl.sv
`ifndef PACKET_ADMISSION_CHECKER_CORE_MACROS_SVH
`define PACKET_ADMISSION_CHECKER_CORE_MACROS_SVH

// same-cycle implication
`define PAC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pac assertion failed");

// next-cycle implication
`define PAC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pac assertion failed");

`endif

[rtl/pac_pkg.sv]
`default_nettype none

package pac_pkg;

  localparam int unsigned PortW     = 3;
  localparam int unsigned PriW      = 3;
  localparam int unsigned AmountW   = 16;
  localparam int unsigned BusWidthW = 13;
  localparam int unsigned MultW     = 8;
  localparam int unsigned NeedW     = AmountW + MultW;
  localparam int unsigned CfgIdxW   = 8;
  localparam int unsigned CfgDataW  = 16;

  typedef enum logic [1:0] {
    OP_WORD      = 2'd0,
    OP_PKT_SPACE = 2'd1,
    OP_DSC_SPACE = 2'd2,
    OP_MTU       = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    WA_NONE        = 2'd0,
    WA_FORWARD     = 2'd1,
    WA_DROP        = 2'd2,
    WA_DROP_NOTIFY = 2'd3
  } word_action_e;

  typedef enum logic [1:0] {
    DA_NONE    = 2'd0,
    DA_FORWARD = 2'd1,
    DA_DISCARD = 2'd2
  } desc_action_e;

  localparam logic [CfgIdxW-1:0] CFG_BUS_WIDTH = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_DATA_MULT = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CFG_DESC_MIN  = CfgIdxW'(2);

  localparam logic [BusWidthW-1:0] BusWidthRst = BusWidthW'(256);
  localparam logic [MultW-1:0]     DataMultRst = MultW'(1);
  localparam logic [AmountW-1:0]   DescMinRst  = AmountW'(1);

  typedef struct packed {
    opcode_e              opcode;
    logic [PortW-1:0]     port;
    logic [PriW-1:0]      priority_req;
    logic                 pkt_start;
    logic                 chunk_first;
    logic                 pkt_end;
    logic                 chunk_last;
    logic [AmountW-1:0]   amount;
  } item_t;

  typedef struct packed {
    word_action_e word_action;
    desc_action_e descriptor_action;
    logic         port_accepted;
  } result_t;

  typedef struct packed {
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_beat_t;

  typedef struct packed {
    logic clear;
    logic load;
    logic div_start;
    logic mul;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_div;
    logic div_done;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/pac_chan_if.sv]
`default_nettype none

interface pac_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[rtl/pac_divider.sv]
`default_nettype none

module pac_divider (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [pac_pkg::AmountW-1:0]     dividend_i,
  input  wire logic [pac_pkg::BusWidthW-1:0]   divisor_i,
  output logic                                 done_o,
  output logic [pac_pkg::AmountW-1:0]          quotient_o,
  output logic                                 rem_nz_o
);

  localparam int unsigned DivW = pac_pkg::AmountW;
  localparam int unsigned DsrW = pac_pkg::BusWidthW;
  localparam int unsigned CntW = $clog2(DivW);

  logic [DivW-1:0] quo_q;
  logic [DsrW-1:0] rem_q;
  logic [CntW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;

  logic [DsrW:0]   trial;
  logic [DsrW:0]   diff;
  logic            ge;
  logic [DsrW-1:0] rem_next;

  // one quotient bit per cycle, restoring
  assign trial    = {rem_q, quo_q[DivW-1]};
  assign ge       = trial >= {1'b0, divisor_i};
  assign diff     = trial - {1'b0, divisor_i};
  assign rem_next = ge ? diff[DsrW-1:0] : trial[DsrW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CntW'(DivW - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DivW-2:0], ge};
      rem_q <= rem_next;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = |rem_q;

endmodule

`default_nettype wire

[rtl/pac_datapath.sv]
`default_nettype none

module pac_datapath #(
  parameter int unsigned NUM_PORTS      = 8,
  parameter int unsigned NUM_PRIORITIES = 8
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire pac_pkg::ctrl_cmd_t    cmd_i,
  output pac_pkg::dp_status_t        st_o,
  input  wire pac_pkg::item_t        item_i,
  input  wire logic                  cfg_valid_i,
  input  wire pac_pkg::cfg_beat_t    cfg_i,
  output pac_pkg::result_t           result_o
);

  localparam int unsigned Depth  = NUM_PORTS * NUM_PRIORITIES;
  localparam int unsigned TblAw  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned PortAw = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
  localparam int unsigned AmountW = pac_pkg::AmountW;
  localparam int unsigned NeedW   = pac_pkg::NeedW;

  pac_pkg::item_t   item_q;
  pac_pkg::result_t result_q;
  pac_pkg::result_t res_d;

  logic [pac_pkg::BusWidthW-1:0] bw_q;
  logic [pac_pkg::BusWidthW-1:0] bw_eff;
  logic [pac_pkg::MultW-1:0]     mult_q;
  logic [AmountW-1:0]            dmin_q;

  logic [AmountW-1:0] pkt_mem [Depth];
  logic [AmountW-1:0] dsc_mem [Depth];
  logic [AmountW-1:0] mtu_mem [NUM_PORTS];
  logic [AmountW-1:0] pkt_rd_q;
  logic [AmountW-1:0] dsc_rd_q;
  logic [AmountW-1:0] mtu_rd_q;

  logic [TblAw-1:0]     clr_q;
  logic [NUM_PORTS-1:0] flags_q;
  logic [NeedW-1:0]     need_q;

  logic                 port_ok;
  logic                 pri_ok;
  logic                 idx_ok;
  logic [PortAw-1:0]    port_sel;
  logic [TblAw-1:0]     tbl_idx;
  logic                 flag;
  logic                 first_word;
  logic                 accept;
  pac_pkg::word_action_e drop_code;

  logic               div_done;
  logic [AmountW-1:0] quo;
  logic               rem_nz;
  logic [AmountW-1:0] entries;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  assign port_ok  = 32'(item_q.port) < NUM_PORTS;
  assign pri_ok   = 32'(item_q.priority_req) < NUM_PRIORITIES;
  assign idx_ok   = port_ok && pri_ok;
  assign port_sel = PortAw'(item_q.port);
  assign tbl_idx  = TblAw'(32'(item_q.port) * NUM_PRIORITIES + 32'(item_q.priority_req));

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bw_q   <= pac_pkg::BusWidthRst;
      mult_q <= pac_pkg::DataMultRst;
      dmin_q <= pac_pkg::DescMinRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_i.index)
        pac_pkg::CFG_BUS_WIDTH: bw_q   <= cfg_i.data[pac_pkg::BusWidthW-1:0];
        pac_pkg::CFG_DATA_MULT: mult_q <= cfg_i.data[pac_pkg::MultW-1:0];
        pac_pkg::CFG_DESC_MIN:  dmin_q <= cfg_i.data[AmountW-1:0];
        default: ;
      endcase
    end
  end

  // clearing sweep address
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else if (cmd_i.clear) begin
      clr_q <= clr_q + 1'b1;
    end
  end

  // space and mtu tables
  always_ff @(posedge clk_i) begin
    pkt_rd_q <= pkt_mem[tbl_idx];
    dsc_rd_q <= dsc_mem[tbl_idx];
    mtu_rd_q <= mtu_mem[port_sel];
    if (cmd_i.clear) begin
      pkt_mem[clr_q] <= '0;
      dsc_mem[clr_q] <= '0;
      if (32'(clr_q) < NUM_PORTS) begin
        mtu_mem[clr_q[PortAw-1:0]] <= '0;
      end
    end else if (cmd_i.finish) begin
      if (item_q.opcode == pac_pkg::OP_PKT_SPACE && idx_ok) begin
        pkt_mem[tbl_idx] <= item_q.amount;
      end
      if (item_q.opcode == pac_pkg::OP_DSC_SPACE && idx_ok) begin
        dsc_mem[tbl_idx] <= item_q.amount;
      end
      if (item_q.opcode == pac_pkg::OP_MTU && port_ok) begin
        mtu_mem[port_sel] <= item_q.amount;
      end
    end
  end

  assign bw_eff = (bw_q == '0) ? pac_pkg::BusWidthW'(1) : bw_q;

  pac_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mtu_rd_q),
    .divisor_i  (bw_eff),
    .done_o     (div_done),
    .quotient_o (quo),
    .rem_nz_o   (rem_nz)
  );

  // ceiling of the quotient
  assign entries = quo + AmountW'(rem_nz);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      need_q <= NeedW'(entries) * NeedW'(mult_q);
    end
  end

  assign flag       = port_ok ? flags_q[port_sel] : 1'b0;
  assign first_word = item_q.opcode == pac_pkg::OP_WORD && item_q.pkt_start &&
                      item_q.chunk_first;
  assign accept     = idx_ok && (need_q <= NeedW'(pkt_rd_q)) && (dmin_q <= dsc_rd_q);
  assign drop_code  = (item_q.pkt_end && item_q.chunk_last) ?
                      pac_pkg::WA_DROP_NOTIFY : pac_pkg::WA_DROP;

  always_comb begin
    res_d.word_action       = pac_pkg::WA_NONE;
    res_d.descriptor_action = pac_pkg::DA_NONE;
    res_d.port_accepted     = flag;
    case (item_q.opcode)
      pac_pkg::OP_WORD: begin
        if (first_word) begin
          if (accept) begin
            res_d.word_action       = pac_pkg::WA_FORWARD;
            res_d.descriptor_action = pac_pkg::DA_FORWARD;
          end else begin
            res_d.word_action       = drop_code;
            res_d.descriptor_action = pac_pkg::DA_DISCARD;
          end
          if (idx_ok) begin
            res_d.port_accepted = accept;
          end
        end else begin
          res_d.word_action = flag ? pac_pkg::WA_FORWARD : drop_code;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (cmd_i.finish && first_word && idx_ok) begin
      flags_q[port_sel] <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      result_q <= res_d;
    end
  end

  assign result_o       = result_q;
  assign st_o.clr_last  = clr_q == TblAw'(Depth - 1);
  assign st_o.need_div  = first_word && idx_ok;
  assign st_o.div_done  = div_done;

endmodule

`default_nettype wire

[rtl/pac_ctrl.sv]
`default_nettype none

`include "packet_admission_checker_core_macros.svh"

module pac_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output pac_pkg::ctrl_cmd_t        cmd_o,
  input  wire pac_pkg::dp_status_t  st_i
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD,
    ST_DSTART,
    ST_DIV,
    ST_MUL,
    ST_FIN
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;

  always_comb begin
    cmd_o.clear     = state_q == ST_CLEAR;
    cmd_o.load      = state_q == ST_IDLE && in_valid_i && in_ready_q;
    cmd_o.div_start = state_q == ST_DSTART;
    cmd_o.mul       = state_q == ST_MUL;
    cmd_o.finish    = state_q == ST_FIN && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      in_ready_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_o.finish) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (st_i.clr_last) begin
            state_q    <= ST_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i && in_ready_q) begin
            state_q    <= ST_RD;
            in_ready_q <= 1'b0;
          end
        end
        ST_RD: begin
          state_q <= st_i.need_div ? ST_DSTART : ST_FIN;
        end
        ST_DSTART: begin
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          if (st_i.div_done) begin
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            in_ready_q  <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = in_ready_q;
  assign out_valid_o = out_valid_q;

  `PAC_ASSERT_IMP(a_load_idle, cmd_o.load, state_q == ST_IDLE)
  `PAC_ASSERT_IMP(a_finish_slot, cmd_o.finish, !out_valid_q || out_ready_i)
  `PAC_ASSERT_IMP(a_div_done_in_div, st_i.div_done, state_q == ST_DIV)
  `PAC_ASSERT_NXT(a_start_div, cmd_o.div_start, state_q == ST_DIV)

endmodule

`default_nettype wire

[rtl/packet_admission_checker_core.sv]
`default_nettype none

// channel    dir   payload               beat taken when
// item_i     in    pac_pkg::item_t       item_i.valid & item_i.ready
// result_o   out   pac_pkg::result_t     result_o.valid & result_o.ready
// cfg_i      in    pac_pkg::cfg_beat_t   cfg_i.valid (ready always high)
//
// first word of a packet with a valid port and priority: the result waits on the
// 16-step restoring divider for ceil(mtu / bus width) and the multiply after it
// other beats: the item passes ST_RD and ST_FIN before its result is registered
// one item at a time; the result register lets the next beat in while it waits,
// a result still held at the end of the next item stalls that item and item_i
// after reset a clearing pass over all NUM_PORTS*NUM_PRIORITIES entries zeroes the
// space and mtu tables, item_i stays not ready meanwhile

module packet_admission_checker_core #(
  parameter int unsigned NUM_PORTS      = 8,
  parameter int unsigned NUM_PRIORITIES = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  pac_chan_if.sink    item_i,
  pac_chan_if.source  result_o,
  pac_chan_if.sink    cfg_i
);

  pac_pkg::ctrl_cmd_t  cmd;
  pac_pkg::dp_status_t st;
  pac_pkg::result_t    result;
  logic                in_ready;
  logic                out_valid;

  pac_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (item_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  pac_datapath #(
    .NUM_PORTS      (NUM_PORTS),
    .NUM_PRIORITIES (NUM_PRIORITIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .st_o        (st),
    .item_i      (item_i.payload),
    .cfg_valid_i (cfg_i.valid),
    .cfg_i       (cfg_i.payload),
    .result_o    (result)
  );

  assign item_i.ready     = in_ready;
  assign result_o.valid   = out_valid;
  assign result_o.payload = result;
  assign cfg_i.ready      = 1'b1;

endmodule

`default_nettype wire
